// File: rtl/core/cau_pkg.sv
package cau_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    // product, exact product sum, scaled dividend, compare width
    localparam int PW = 2 * DATA_WIDTH;
    localparam int SW = PW + 1;
    localparam int NW = PW + FRAC_BITS;
    localparam int CW = (NW > PW + DATA_WIDTH) ? NW : PW + DATA_WIDTH;

    // three front stages, one stage per quotient bit, one output stage
    localparam int NSTAGE = DATA_WIDTH + 4;
    localparam int FIRST_STEP = 3;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_OVF = 2'd1,
        ST_DZ  = 2'd2
    } t_status;

    localparam logic [DATA_WIDTH-1:0] VAL_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] VAL_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // Result of the non-divide paths, plus sign and range flags of a divide.
    typedef struct packed {
        logic [DATA_WIDTH-1:0] re;
        logic [DATA_WIDTH-1:0] im;
        t_status               st;
        logic                  div;
        logic                  neg_re;
        logic                  neg_im;
        logic                  big_re;
        logic                  big_im;
    } t_side;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] val;
        logic                  ovf;
    } t_sat;

    function automatic t_sat saturate(input logic [SW-1:0] x);
        t_sat                   r;
        logic [SW-DATA_WIDTH:0] hi;
        hi = x[SW-1:DATA_WIDTH-1];
        if ((&hi) || !(|hi)) begin
            r.val = x[DATA_WIDTH-1:0];
            r.ovf = 1'b0;
        end else begin
            r.val = x[SW-1] ? VAL_MIN : VAL_MAX;
            r.ovf = 1'b1;
        end
        return r;
    endfunction

    // Apply the quotient sign and clamp to the signed range.
    function automatic t_sat fix_quot(input logic [DATA_WIDTH-1:0] q,
                                      input logic neg, input logic big);
        t_sat r;
        if (big) begin
            r.val = neg ? VAL_MIN : VAL_MAX;
            r.ovf = 1'b1;
        end else if (neg) begin
            r.ovf = q > VAL_MIN;
            r.val = r.ovf ? VAL_MIN : DATA_WIDTH'(~q + 1'b1);
        end else begin
            r.ovf = q > VAL_MAX;
            r.val = r.ovf ? VAL_MAX : q;
        end
        return r;
    endfunction

endpackage

// File: rtl/core/complex_arith_unit_top.sv
// Complex arithmetic unit: add, subtract, multiply and divide of two complex
// operands in signed Q16.16, one transaction in and one result out. The unit is
// a fully pipelined chain of DATA_WIDTH+4 (36) register stages: products, exact
// sums, divide setup, one stage per quotient bit of a restoring divider, and an
// output register. It takes a new transaction every cycle while the output is not
// stalled; every result passes through all stages, whatever the opcode;
// the depth is set by the quotient-bit stages. Each stage keeps a valid bit and
// holds only when the stage ahead of it is full and stalled, so bubbles close
// up and input is taken while a finished result waits on o_valid.
// Multiply shifts the exact product sum right by 16 (rounds toward minus
// infinity); divide forms A*conj(B)/|B|^2 truncated toward zero. Each result
// part saturates on its own and sets status 1; a divide by zero gives a zero
// result with status 2.
module complex_arith_unit_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [1:0]                      i_opcode,
    input  logic [cau_pkg::DATA_WIDTH-1:0]  i_a_re,
    input  logic [cau_pkg::DATA_WIDTH-1:0]  i_a_im,
    input  logic [cau_pkg::DATA_WIDTH-1:0]  i_b_re,
    input  logic [cau_pkg::DATA_WIDTH-1:0]  i_b_im,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [cau_pkg::DATA_WIDTH-1:0]  o_res_re,
    output logic [cau_pkg::DATA_WIDTH-1:0]  o_res_im,
    output logic [1:0]                      o_status
);
    localparam int DW = cau_pkg::DATA_WIDTH;
    localparam int NS = cau_pkg::NSTAGE;
    localparam int FS = cau_pkg::FIRST_STEP;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] en;

    cau_pkg::t_side               side_w [DW+1];
    logic [cau_pkg::NW-1:0]       rem_re_w [DW+1];
    logic [cau_pkg::NW-1:0]       rem_im_w [DW+1];
    logic [DW-1:0]                q_re_w [DW+1];
    logic [DW-1:0]                q_im_w [DW+1];
    logic [cau_pkg::CW-1:0]       ds_w [DW+1];

    // A stage loads when it is empty or the stage ahead loads too.
    always_comb begin
        en[NS-1] = !r_vld[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_vld[NS-1];

    // Advance valid bits with the data; hold them on a stall.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (en[k]) begin
                    r_vld[k] <= (k == 0) ? i_valid : r_vld[(k == 0) ? 0 : k-1];
                end
            end
        end
    end

    cau_front u_front (
        .i_clk    (i_clk),
        .i_en     (en[2:0]),
        .i_opcode (i_opcode),
        .i_a_re   (i_a_re),
        .i_a_im   (i_a_im),
        .i_b_re   (i_b_re),
        .i_b_im   (i_b_im),
        .o_side   (side_w[0]),
        .o_rem_re (rem_re_w[0]),
        .o_rem_im (rem_im_w[0]),
        .o_ds     (ds_w[0])
    );

    assign q_re_w[0] = '0;
    assign q_im_w[0] = '0;

    // One quotient bit per stage, most significant first.
    for (genvar g = 0; g < DW; g++) begin : g_step
        cau_div_step u_step (
            .i_clk    (i_clk),
            .i_en     (en[FS+g]),
            .i_side   (side_w[g]),
            .i_rem_re (rem_re_w[g]),
            .i_rem_im (rem_im_w[g]),
            .i_q_re   (q_re_w[g]),
            .i_q_im   (q_im_w[g]),
            .i_ds     (ds_w[g]),
            .o_side   (side_w[g+1]),
            .o_rem_re (rem_re_w[g+1]),
            .o_rem_im (rem_im_w[g+1]),
            .o_q_re   (q_re_w[g+1]),
            .o_q_im   (q_im_w[g+1]),
            .o_ds     (ds_w[g+1])
        );
    end

    cau_back u_back (
        .i_clk    (i_clk),
        .i_en     (en[NS-1]),
        .i_side   (side_w[DW]),
        .i_q_re   (q_re_w[DW]),
        .i_q_im   (q_im_w[DW]),
        .o_res_re (o_res_re),
        .o_res_im (o_res_im),
        .o_status (o_status)
    );

endmodule

// File: rtl/core/cau_front.sv
module cau_front (
    input  logic                                i_clk,
    input  logic [2:0]                          i_en,
    input  logic [1:0]                          i_opcode,
    input  logic [cau_pkg::DATA_WIDTH-1:0]      i_a_re,
    input  logic [cau_pkg::DATA_WIDTH-1:0]      i_a_im,
    input  logic [cau_pkg::DATA_WIDTH-1:0]      i_b_re,
    input  logic [cau_pkg::DATA_WIDTH-1:0]      i_b_im,
    output cau_pkg::t_side                      o_side,
    output logic [cau_pkg::NW-1:0]              o_rem_re,
    output logic [cau_pkg::NW-1:0]              o_rem_im,
    output logic [cau_pkg::CW-1:0]              o_ds
);
    localparam int DW = cau_pkg::DATA_WIDTH;
    localparam int PW = cau_pkg::PW;
    localparam int SW = cau_pkg::SW;
    localparam int NW = cau_pkg::NW;
    localparam int CW = cau_pkg::CW;
    localparam int FRAC_ZERO = cau_pkg::FRAC_BITS;

    // stage 0: products and part sums
    cau_pkg::t_op            r_op0;
    logic                    r_zero0;
    logic signed [PW-1:0]    r_rr, r_ii, r_ir, r_ri, r_brbr, r_bibi;
    logic [DW:0]             r_as_re0, r_as_im0;

    // stage 1: exact sums
    cau_pkg::t_op            r_op1;
    logic                    r_zero1;
    logic [SW-1:0]           r_num_re, r_num_im;
    logic [PW-1:0]           r_den;
    logic [DW:0]             r_as_re1, r_as_im1;

    // stage 2 outputs
    cau_pkg::t_side          r_side;
    logic [NW-1:0]           r_rem_re, r_rem_im;
    logic [CW-1:0]           r_ds;

    logic [DW:0]             n_as_re, n_as_im;
    logic [SW-1:0]           s_rr, s_ii, s_ir, s_ri;
    cau_pkg::t_side          n_side;
    logic [NW-1:0]           n_rem_re, n_rem_im;
    logic [PW-1:0]           mag_re, mag_im;
    logic [CW-1:0]           den_top;
    logic [SW-1:0]           ext_re, ext_im;
    cau_pkg::t_sat           sat_re, sat_im;

    always_comb begin
        if (cau_pkg::t_op'(i_opcode) == cau_pkg::OP_SUB) begin
            n_as_re = {i_a_re[DW-1], i_a_re} - {i_b_re[DW-1], i_b_re};
            n_as_im = {i_a_im[DW-1], i_a_im} - {i_b_im[DW-1], i_b_im};
        end else begin
            n_as_re = {i_a_re[DW-1], i_a_re} + {i_b_re[DW-1], i_b_re};
            n_as_im = {i_a_im[DW-1], i_a_im} + {i_b_im[DW-1], i_b_im};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_op0    <= cau_pkg::t_op'(i_opcode);
            r_zero0  <= (i_b_re == '0) && (i_b_im == '0);
            r_rr     <= $signed(i_a_re) * $signed(i_b_re);
            r_ii     <= $signed(i_a_im) * $signed(i_b_im);
            r_ir     <= $signed(i_a_im) * $signed(i_b_re);
            r_ri     <= $signed(i_a_re) * $signed(i_b_im);
            r_brbr   <= $signed(i_b_re) * $signed(i_b_re);
            r_bibi   <= $signed(i_b_im) * $signed(i_b_im);
            r_as_re0 <= n_as_re;
            r_as_im0 <= n_as_im;
        end
    end

    assign s_rr = {r_rr[PW-1], r_rr};
    assign s_ii = {r_ii[PW-1], r_ii};
    assign s_ir = {r_ir[PW-1], r_ir};
    assign s_ri = {r_ri[PW-1], r_ri};

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_op1    <= r_op0;
            r_zero1  <= r_zero0;
            r_num_re <= (r_op0 == cau_pkg::OP_MUL) ? s_rr - s_ii : s_rr + s_ii;
            r_num_im <= (r_op0 == cau_pkg::OP_MUL) ? s_ir + s_ri : s_ir - s_ri;
            r_den    <= r_brbr + r_bibi;
            r_as_re1 <= r_as_re0;
            r_as_im1 <= r_as_im0;
        end
    end

    always_comb begin
        mag_re  = r_num_re[SW-1] ? PW'(~r_num_re + 1'b1) : r_num_re[PW-1:0];
        mag_im  = r_num_im[SW-1] ? PW'(~r_num_im + 1'b1) : r_num_im[PW-1:0];
        n_rem_re = {mag_re, {FRAC_ZERO{1'b0}}};
        n_rem_im = {mag_im, {FRAC_ZERO{1'b0}}};
        den_top  = CW'(r_den) << DW;

        if (r_op1 == cau_pkg::OP_MUL) begin
            ext_re = $signed(r_num_re) >>> cau_pkg::FRAC_BITS;
            ext_im = $signed(r_num_im) >>> cau_pkg::FRAC_BITS;
        end else begin
            ext_re = {{(SW-DW-1){r_as_re1[DW]}}, r_as_re1};
            ext_im = {{(SW-DW-1){r_as_im1[DW]}}, r_as_im1};
        end
        sat_re = cau_pkg::saturate(ext_re);
        sat_im = cau_pkg::saturate(ext_im);

        n_side.re     = sat_re.val;
        n_side.im     = sat_im.val;
        n_side.st     = (sat_re.ovf || sat_im.ovf) ? cau_pkg::ST_OVF : cau_pkg::ST_OK;
        n_side.div    = 1'b0;
        n_side.neg_re = r_num_re[SW-1];
        n_side.neg_im = r_num_im[SW-1];
        n_side.big_re = CW'(n_rem_re) >= den_top;
        n_side.big_im = CW'(n_rem_im) >= den_top;
        if (r_op1 == cau_pkg::OP_DIV) begin
            if (r_zero1) begin
                n_side.re = '0;
                n_side.im = '0;
                n_side.st = cau_pkg::ST_DZ;
            end else begin
                n_side.div = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_side   <= n_side;
            r_rem_re <= n_rem_re;
            r_rem_im <= n_rem_im;
            r_ds     <= CW'(r_den) << (DW - 1);
        end
    end

    assign o_side   = r_side;
    assign o_rem_re = r_rem_re;
    assign o_rem_im = r_rem_im;
    assign o_ds     = r_ds;

endmodule

// File: rtl/core/cau_div_step.sv
module cau_div_step (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  cau_pkg::t_side                  i_side,
    input  logic [cau_pkg::NW-1:0]          i_rem_re,
    input  logic [cau_pkg::NW-1:0]          i_rem_im,
    input  logic [cau_pkg::DATA_WIDTH-1:0]  i_q_re,
    input  logic [cau_pkg::DATA_WIDTH-1:0]  i_q_im,
    input  logic [cau_pkg::CW-1:0]          i_ds,
    output cau_pkg::t_side                  o_side,
    output logic [cau_pkg::NW-1:0]          o_rem_re,
    output logic [cau_pkg::NW-1:0]          o_rem_im,
    output logic [cau_pkg::DATA_WIDTH-1:0]  o_q_re,
    output logic [cau_pkg::DATA_WIDTH-1:0]  o_q_im,
    output logic [cau_pkg::CW-1:0]          o_ds
);
    localparam int NW = cau_pkg::NW;
    localparam int CW = cau_pkg::CW;
    localparam int DW = cau_pkg::DATA_WIDTH;

    logic bit_re, bit_im;

    cau_pkg::t_side    r_side;
    logic [NW-1:0]     r_rem_re, r_rem_im;
    logic [DW-1:0]     r_q_re, r_q_im;
    logic [CW-1:0]     r_ds;

    // restoring step: take the shifted divisor out where it fits
    assign bit_re = CW'(i_rem_re) >= i_ds;
    assign bit_im = CW'(i_rem_im) >= i_ds;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side   <= i_side;
            r_rem_re <= bit_re ? i_rem_re - i_ds[NW-1:0] : i_rem_re;
            r_rem_im <= bit_im ? i_rem_im - i_ds[NW-1:0] : i_rem_im;
            r_q_re   <= {i_q_re[DW-2:0], bit_re};
            r_q_im   <= {i_q_im[DW-2:0], bit_im};
            r_ds     <= i_ds >> 1;
        end
    end

    assign o_side   = r_side;
    assign o_rem_re = r_rem_re;
    assign o_rem_im = r_rem_im;
    assign o_q_re   = r_q_re;
    assign o_q_im   = r_q_im;
    assign o_ds     = r_ds;

endmodule

// File: rtl/core/cau_back.sv
module cau_back (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  cau_pkg::t_side                  i_side,
    input  logic [cau_pkg::DATA_WIDTH-1:0]  i_q_re,
    input  logic [cau_pkg::DATA_WIDTH-1:0]  i_q_im,
    output logic [cau_pkg::DATA_WIDTH-1:0]  o_res_re,
    output logic [cau_pkg::DATA_WIDTH-1:0]  o_res_im,
    output logic [1:0]                      o_status
);
    cau_pkg::t_sat                       f_re, f_im;
    logic [cau_pkg::DATA_WIDTH-1:0]      r_re, r_im;
    cau_pkg::t_status                    r_st;

    assign f_re = cau_pkg::fix_quot(i_q_re, i_side.neg_re, i_side.big_re);
    assign f_im = cau_pkg::fix_quot(i_q_im, i_side.neg_im, i_side.big_im);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_side.div) begin
                r_re <= f_re.val;
                r_im <= f_im.val;
                r_st <= (f_re.ovf || f_im.ovf) ? cau_pkg::ST_OVF : cau_pkg::ST_OK;
            end else begin
                r_re <= i_side.re;
                r_im <= i_side.im;
                r_st <= i_side.st;
            end
        end
    end

    assign o_res_re = r_re;
    assign o_res_im = r_im;
    assign o_status = r_st;

endmodule

// File: rtl/core/cau_checker.sv
module cau_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_valid,
    input logic                            i_ready,
    input logic [cau_pkg::DATA_WIDTH-1:0]  o_res_re,
    input logic [cau_pkg::DATA_WIDTH-1:0]  o_res_im,
    input logic [1:0]                      o_status
);
    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_res_re) && $stable(o_res_im)
            && $stable(o_status))
        else $error("result changed while stalled");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status == cau_pkg::ST_OK || o_status == cau_pkg::ST_OVF
            || o_status == cau_pkg::ST_DZ)
        else $error("unknown status code");

    a_dz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == cau_pkg::ST_DZ |-> o_res_re == '0 && o_res_im == '0)
        else $error("divide by zero with nonzero result");

    a_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == cau_pkg::ST_OVF |->
            o_res_re == cau_pkg::VAL_MAX || o_res_re == cau_pkg::VAL_MIN
            || o_res_im == cau_pkg::VAL_MAX || o_res_im == cau_pkg::VAL_MIN)
        else $error("overflow status without a saturated part");

endmodule

bind complex_arith_unit_top cau_checker u_cau_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_valid  (o_valid),
    .i_ready  (i_ready),
    .o_res_re (o_res_re),
    .o_res_im (o_res_im),
    .o_status (o_status)
);
